### hdl/ffc_pkg.sv
// Shared types and constants for the fixed/float converter.
package ffc_pkg;
    localparam int WordWidth = 32;

    typedef enum logic {
        CMD_FIX_TO_FLT = 1'b0,
        CMD_FLT_TO_FIX = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [WordWidth-1:0] converted;
        logic                 saturated;
    } result_t;

    localparam logic [WordWidth-1:0] FixMax = 32'h7FFF_FFFF;
    localparam logic [WordWidth-1:0] FixMin = 32'h8000_0000;
endpackage

### hdl/ffc_core.sv
// Combinational conversion between signed 16.16 fixed point and IEEE single.
module ffc_core (
    input  logic                     command,
    input  logic [ffc_pkg::WordWidth-1:0] operand,
    output ffc_pkg::result_t         result
);
    import ffc_pkg::*;

    // Fixed to float.
    logic        f_sign;
    logic [31:0] f_mag;
    logic [4:0]  f_msb;
    logic [31:0] f_norm;
    logic [23:0] f_mant;
    logic        f_guard;
    logic        f_sticky;
    logic        f_up;
    logic [31:0] f_word;

    // Float to fixed.
    logic        g_neg;
    logic [7:0]  g_ex;
    logic [22:0] g_frac;
    logic [23:0] g_sig;
    logic [7:0]  g_exe;
    logic [31:0] g_mag;
    logic        g_big;
    logic [31:0] g_word;
    logic        g_sat;
    logic [7:0]  g_rsh;
    logic [55:0] g_wide;

    always_comb begin
        f_sign = operand[31];
        f_mag  = f_sign ? (32'd0 - operand) : operand;
        f_msb  = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (f_mag[i]) begin
                f_msb = 5'(i);
            end
        end
        // Left-justify so the leading one sits at bit 31.
        f_norm   = f_mag << (5'd31 - f_msb);
        f_mant   = f_norm[31:8];
        f_guard  = f_norm[7];
        f_sticky = |f_norm[6:0];
        f_up     = f_guard && (f_sticky || f_mant[0]);
        // The implicit bit of the mantissa adds one to the exponent field,
        // and a rounding carry moves the exponent on by itself.
        f_word = {f_sign, 31'd0}
               + ({24'd0, 8'(f_msb) + 8'd110} << 23)
               + {8'd0, f_mant} + {31'd0, f_up};
        if (f_mag == 32'd0) begin
            f_word = 32'd0;
        end

        g_neg  = operand[31];
        g_ex   = operand[30:23];
        g_frac = operand[22:0];
        g_sig  = (g_ex == 8'd0) ? {1'b0, g_frac} : {1'b1, g_frac};
        g_exe  = (g_ex == 8'd0) ? 8'd1 : g_ex;
        // Value*65536 is sig shifted by exe-134; 143 and up saturates.
        g_big  = g_exe >= 8'd143;
        g_wide = {g_sig, 32'd0};
        g_rsh  = 8'd166 - g_exe;   // used only when exe < 143, so >= 24
        g_mag  = (g_rsh >= 8'd56) ? 32'd0 : 32'(g_wide >> g_rsh);
        g_sat  = 1'b0;
        if (g_ex == 8'hFF && g_frac != 23'd0) begin
            g_sat  = 1'b1;
            g_word = 32'd0;
        end else if (g_big) begin
            g_sat  = 1'b1;
            g_word = g_neg ? FixMin : FixMax;
        end else if (g_neg) begin
            if (g_mag > FixMin) begin
                g_sat  = 1'b1;
                g_word = FixMin;
            end else begin
                g_word = 32'd0 - g_mag;
            end
        end else if (g_mag > FixMax) begin
            g_sat  = 1'b1;
            g_word = FixMax;
        end else begin
            g_word = g_mag;
        end

        case (cmd_t'(command))
            CMD_FIX_TO_FLT: begin
                result.converted = f_word;
                result.saturated = 1'b0;
            end
            CMD_FLT_TO_FIX: begin
                result.converted = g_word;
                result.saturated = g_sat;
            end
            default: begin
                result.converted = f_word;
                result.saturated = 1'b0;
            end
        endcase
    end
endmodule

### hdl/fixed_float_converter.sv
// Top level of the fixed/float converter.
// Converts one word per beat between signed 16.16 fixed point and IEEE single
// (command 0: fixed to float, round to nearest even; command 1: float to
// fixed, truncated toward zero, clamped on range overflow and zero on NaN,
// with saturated set on either). Each beat is registered at the input,
// converted by one pass of combinational logic and held in an output
// register; m_valid rises once the beat reaches the output register, and one
// beat per cycle is sustained while m_ready stays high.
// An output skid stage takes the beat in flight when m_ready drops, so s_ready
// falls only once that stage is full, with at most three beats held inside.
module fixed_float_converter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [ffc_pkg::WordWidth-1:0] s_operand,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ffc_pkg::WordWidth-1:0] m_converted,
    output logic                          m_saturated
);
    import ffc_pkg::*;

    logic                 in_valid_reg;
    logic                 in_cmd_reg;
    logic [WordWidth-1:0] in_word_reg;
    logic                 out_valid_reg;
    result_t              out_reg;
    logic                 skid_valid_reg;
    result_t              skid_reg;
    result_t              core_result;
    logic                 out_free;

    ffc_core u_core (
        .command (in_cmd_reg),
        .operand (in_word_reg),
        .result  (core_result)
    );

    assign out_free = !out_valid_reg || m_ready;
    // The input stage moves whenever the skid slot is empty.
    assign s_ready  = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_cmd_reg  <= s_command;
            in_word_reg <= s_operand;
        end
        if (out_free) begin
            out_reg <= skid_valid_reg ? skid_reg : core_result;
        end
        if (!skid_valid_reg && in_valid_reg && !out_free) begin
            skid_reg <= core_result;
        end
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg  <= skid_valid_reg || in_valid_reg;
                skid_valid_reg <= 1'b0;
            end else if (!skid_valid_reg && in_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_converted = out_reg.converted;
    assign m_saturated = out_reg.saturated;
endmodule
